FILE: rtl/mbs_pkg.sv
// Shared types, field widths and codes for the maze backtracker step block.
// No dependencies; compiled first.
package mbs_pkg;

  // Field widths of the request, result and configuration channels
  localparam int CMD_W      = 1;
  localparam int RND_W      = 8;
  localparam int ACT_W      = 2;
  localparam int COORD_W    = 6;
  localparam int DIR_W      = 2;
  localparam int COUNT_W    = 13;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CELL_W     = 5;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_CARVE   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 2'd3;

  // Cell store bits
  localparam logic [CELL_W-1:0] CELL_VISITED = 5'b00001;
  localparam logic [CELL_W-1:0] OPEN_NEG_Y   = 5'b00010;
  localparam logic [CELL_W-1:0] OPEN_POS_Y   = 5'b00100;
  localparam logic [CELL_W-1:0] OPEN_NEG_X   = 5'b01000;
  localparam logic [CELL_W-1:0] OPEN_POS_X   = 5'b10000;

  typedef enum logic [ACT_W-1:0] {
    ACT_CARVE     = 2'd0,
    ACT_BACKTRACK = 2'd1,
    ACT_COMPLETE  = 2'd2,
    ACT_RESTART   = 2'd3
  } action_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_POS_Y = 2'd0,
    DIR_NEG_Y = 2'd1,
    DIR_NEG_X = 2'd2,
    DIR_POS_X = 2'd3
  } dir_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [RND_W-1:0] random_value;
  } step_req_t;

  typedef struct packed {
    action_e            action;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    dir_e               direction;
    logic [COUNT_W-1:0] cells_visited;
    logic [COUNT_W-1:0] stack_depth;
  } step_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

  // Wall bit opened in the cell we leave
  function automatic logic [CELL_W-1:0] side_here_f(input dir_e dir);
    logic [CELL_W-1:0] side;
    case (dir)
      DIR_POS_Y: side = OPEN_POS_Y;
      DIR_NEG_Y: side = OPEN_NEG_Y;
      DIR_NEG_X: side = OPEN_NEG_X;
      DIR_POS_X: side = OPEN_POS_X;
      default:   side = '0;
    endcase
    return side;
  endfunction

  // Wall bit opened in the cell we enter
  function automatic logic [CELL_W-1:0] side_there_f(input dir_e dir);
    logic [CELL_W-1:0] side;
    case (dir)
      DIR_POS_Y: side = OPEN_NEG_Y;
      DIR_NEG_Y: side = OPEN_POS_Y;
      DIR_NEG_X: side = OPEN_POS_X;
      DIR_POS_X: side = OPEN_NEG_X;
      default:   side = '0;
    endcase
    return side;
  endfunction

  // Remainder by three: fold base-4 digits (4 == 1 mod 3), then one subtract
  function automatic logic [1:0] mod3_f(input logic [RND_W-1:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

endpackage

FILE: rtl/mbs_chan_if.sv
// Valid/ready channel carrying one payload type per request.
// Payload types come from mbs_pkg at instantiation.
interface mbs_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/maze_backtracker_step.sv
// Depth-first maze carver, one move per request; cell store and path stack in two
// synchronous memories. Uses mbs_pkg and mbs_chan_if. One request in flight; a carve
// reads the four neighbours and the current cell, then makes two writes on the cell store.
// Reset clears the whole store with the step channel not ready; config writes always taken.
module maze_backtracker_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbs_chan_if.sink   step_i,
  mbs_chan_if.source result_o,
  mbs_chan_if.sink   cfg_i
);
  import mbs_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CXW   = CW + 1;
  localparam int RXW   = RW + 1;
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int CMP_A = (CXW > RXW) ? CXW : RXW;
  localparam int CMP_W = (CMP_A > SIZE_W) ? CMP_A : SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PICK,
    S_WRITE,
    S_POP,
    S_SWEEP,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0]  grid_w_q, grid_h_q;
  logic [COORD_W-1:0] start_x_q, start_y_q;

  // Walk state and per-request working registers
  state_e             state_q;
  logic [CW-1:0]      cur_col_q, from_col_q;
  logic [RW-1:0]      cur_row_q, from_row_q;
  logic [CNT_W-1:0]   sp_q, visited_q;
  logic [AW-1:0]      sweep_q;
  logic               reply_q;
  logic [2:0]         probe_q;
  logic [3:0]         free_q;
  logic [RND_W-1:0]   rnd_q;
  dir_e               dir_q;
  action_e            action_q;
  logic               out_valid_q;
  step_res_t          out_q;

  // Memories
  logic [CELL_W-1:0]  cell_mem [CELLS];
  logic [RW+CW-1:0]   stack_mem [CELLS];
  logic [CELL_W-1:0]  cell_rdata_q;
  logic [RW+CW-1:0]   stack_rdata_q;

  logic               cell_we, stack_we;
  logic [AW-1:0]      cell_waddr, cell_raddr, stack_waddr, stack_raddr;
  logic [CELL_W-1:0]  cell_wdata;
  logic [RW+CW-1:0]   stack_wdata;

  logic [CMP_W-1:0]   gw_ext, gh_ext;
  logic [CXW-1:0]     w_eff;
  logic [RXW-1:0]     h_eff;
  logic [CNT_W-1:0]   area;
  logic [CW-1:0]      start_col;
  logic [RW-1:0]      start_row;

  logic [CXW-1:0]     nbr_col [4];
  logic [RXW-1:0]     nbr_row [4];
  logic [AW-1:0]      nbr_addr [4];
  logic [3:0]         nbr_in;
  logic [AW-1:0]      cur_addr;

  logic [2:0]         free_cnt;
  logic [1:0]         pick_rank;
  logic [1:0]         pick_sel;
  dir_e               pick_dir;
  logic [1:0]         cap_idx;
  logic               step_accept;

  assign cfg_i.ready    = 1'b1;
  assign step_i.ready   = (state_q == S_IDLE);
  assign step_accept    = step_i.valid && step_i.ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // Clamp grid size and start cell to the usable range
  always_comb begin
    gw_ext = CMP_W'(grid_w_q);
    gh_ext = CMP_W'(grid_h_q);
    if (gw_ext == '0) begin
      w_eff = CXW'(1);
    end else if (gw_ext > CMP_W'(MAX_COLS)) begin
      w_eff = CXW'(MAX_COLS);
    end else begin
      w_eff = CXW'(gw_ext);
    end
    if (gh_ext == '0) begin
      h_eff = RXW'(1);
    end else if (gh_ext > CMP_W'(MAX_ROWS)) begin
      h_eff = RXW'(MAX_ROWS);
    end else begin
      h_eff = RXW'(gh_ext);
    end
    area = CNT_W'(w_eff) * CNT_W'(h_eff);
    if (CMP_W'(start_x_q) >= CMP_W'(w_eff)) begin
      start_col = CW'(w_eff - CXW'(1));
    end else begin
      start_col = CW'(start_x_q);
    end
    if (CMP_W'(start_y_q) >= CMP_W'(h_eff)) begin
      start_row = RW'(h_eff - RXW'(1));
    end else begin
      start_row = RW'(start_y_q);
    end
  end

  // Neighbour coordinates in +y, -y, -x, +x order; underflow wraps out of range
  always_comb begin
    nbr_col[0] = CXW'(cur_col_q);
    nbr_row[0] = RXW'(cur_row_q) + RXW'(1);
    nbr_col[1] = CXW'(cur_col_q);
    nbr_row[1] = RXW'(cur_row_q) - RXW'(1);
    nbr_col[2] = CXW'(cur_col_q) - CXW'(1);
    nbr_row[2] = RXW'(cur_row_q);
    nbr_col[3] = CXW'(cur_col_q) + CXW'(1);
    nbr_row[3] = RXW'(cur_row_q);
    for (int d = 0; d < 4; d++) begin
      nbr_in[d]   = (nbr_col[d] < w_eff) && (nbr_row[d] < h_eff);
      nbr_addr[d] = cell_addr(RW'(nbr_row[d]), CW'(nbr_col[d]));
    end
    cur_addr = cell_addr(cur_row_q, cur_col_q);
    cap_idx  = 2'(probe_q - 3'd1);
  end

  // Choose among free neighbours: rank = random mod count, then the rank-th set bit
  always_comb begin
    logic [1:0] below;
    free_cnt = 3'(free_q[0]) + 3'(free_q[1]) + 3'(free_q[2]) + 3'(free_q[3]);
    case (free_cnt)
      3'd2:    pick_rank = {1'b0, rnd_q[0]};
      3'd3:    pick_rank = mod3_f(rnd_q);
      3'd4:    pick_rank = rnd_q[1:0];
      default: pick_rank = 2'd0;
    endcase
    below    = 2'd0;
    pick_sel = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (free_q[d] && (below == pick_rank)) begin
        pick_sel = 2'(d);
      end
      below = below + 2'(free_q[d]);
    end
    pick_dir = dir_e'(pick_sel);
  end

  // Memory port control
  always_comb begin
    cell_we     = 1'b0;
    cell_waddr  = cur_addr;
    cell_wdata  = '0;
    stack_we    = 1'b0;
    stack_waddr = AW'(sp_q);
    stack_wdata = {cur_row_q, cur_col_q};
    stack_raddr = AW'(sp_q - CNT_W'(2));
    if ((state_q == S_PROBE) && (probe_q == 3'd4)) begin
      cell_raddr = cur_addr;
    end else if (state_q == S_PROBE) begin
      cell_raddr = nbr_addr[probe_q[1:0]];
    end else begin
      cell_raddr = nbr_addr[0];
    end
    case (state_q)
      S_PICK: begin
        if (free_cnt != 3'd0) begin
          cell_we    = 1'b1;
          cell_wdata = cell_rdata_q | side_here_f(pick_dir);
        end
      end
      S_WRITE: begin
        cell_we    = 1'b1;
        cell_wdata = side_there_f(dir_q) | CELL_VISITED;
        stack_we   = (sp_q < CNT_W'(CELLS));
      end
      S_SWEEP: begin
        cell_we     = 1'b1;
        cell_waddr  = sweep_q;
        cell_wdata  = (sweep_q == cur_addr) ? CELL_VISITED : '0;
        stack_we    = (sweep_q == '0);
        stack_waddr = '0;
      end
      default: ;
    endcase
  end

  // Cell store and path stack; accesses never overlap, one request at a time
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= SIZE_W'(16);
      grid_h_q  <= SIZE_W'(16);
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        REG_GRID_WIDTH:  grid_w_q  <= cfg_i.data.value;
        REG_GRID_HEIGHT: grid_h_q  <= cfg_i.data.value;
        REG_START_X:     start_x_q <= COORD_W'(cfg_i.data.value);
        REG_START_Y:     start_y_q <= COORD_W'(cfg_i.data.value);
        default: ;
      endcase
    end
  end

  // Step sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      from_col_q  <= '0;
      from_row_q  <= '0;
      sp_q        <= CNT_W'(1);
      visited_q   <= CNT_W'(1);
      sweep_q     <= '0;
      reply_q     <= 1'b0;
      probe_q     <= '0;
      free_q      <= '0;
      rnd_q       <= '0;
      dir_q       <= DIR_POS_Y;
      action_q    <= ACT_COMPLETE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the result once taken
      if (result_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (step_accept) begin
            from_col_q <= cur_col_q;
            from_row_q <= cur_row_q;
            rnd_q      <= step_i.data.random_value;
            dir_q      <= DIR_POS_Y;
            if (step_i.data.command == CMD_RESTART) begin
              cur_col_q <= start_col;
              cur_row_q <= start_row;
              sp_q      <= CNT_W'(1);
              visited_q <= CNT_W'(1);
              sweep_q   <= '0;
              reply_q   <= 1'b1;
              action_q  <= ACT_RESTART;
              state_q   <= S_SWEEP;
            end else if (visited_q >= area) begin
              action_q <= ACT_COMPLETE;
              state_q  <= S_DONE;
            end else begin
              probe_q <= 3'd1;
              free_q  <= '0;
              state_q <= S_PROBE;
            end
          end
        end
        // Collect neighbour visited bits, one read per cycle
        S_PROBE: begin
          free_q[cap_idx] <= nbr_in[cap_idx] && !cell_rdata_q[0];
          if (probe_q == 3'd4) begin
            state_q <= S_PICK;
          end else begin
            probe_q <= probe_q + 3'd1;
          end
        end
        S_PICK: begin
          if (free_cnt != 3'd0) begin
            cur_col_q <= CW'(nbr_col[pick_sel]);
            cur_row_q <= RW'(nbr_row[pick_sel]);
            dir_q     <= pick_dir;
            action_q  <= ACT_CARVE;
            state_q   <= S_WRITE;
          end else if (sp_q > CNT_W'(1)) begin
            action_q <= ACT_BACKTRACK;
            state_q  <= S_POP;
          end else begin
            action_q <= ACT_COMPLETE;
            state_q  <= S_DONE;
          end
        end
        // Mark the new cell and push it
        S_WRITE: begin
          visited_q <= visited_q + CNT_W'(1);
          if (sp_q < CNT_W'(CELLS)) begin
            sp_q <= sp_q + CNT_W'(1);
          end
          state_q <= S_DONE;
        end
        S_POP: begin
          cur_row_q <= stack_rdata_q[RW+CW-1:CW];
          cur_col_q <= stack_rdata_q[CW-1:0];
          sp_q      <= sp_q - CNT_W'(1);
          state_q   <= S_DONE;
        end
        // Clear the cell store, seed the start cell and stack entry zero
        S_SWEEP: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == AW'(CELLS - 1)) begin
            state_q <= reply_q ? S_DONE : S_IDLE;
            reply_q <= 1'b0;
          end
        end
        S_DONE: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q         <= 1'b1;
            out_q.action        <= action_q;
            out_q.from_x        <= COORD_W'(from_col_q);
            out_q.from_y        <= COORD_W'(from_row_q);
            out_q.to_x          <= COORD_W'(cur_col_q);
            out_q.to_y          <= COORD_W'(cur_row_q);
            out_q.direction     <= dir_q;
            out_q.cells_visited <= COUNT_W'(visited_q);
            out_q.stack_depth   <= COUNT_W'(sp_q);
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Every stacked cell was visited once
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= visited_q)
    else $error("path stack deeper than visited count");

  // A restart request enters the clearing pass with one cell on the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_accept && (step_i.data.command == CMD_RESTART)
      |=> (state_q == S_SWEEP) && (sp_q == CNT_W'(1)) && (visited_q == CNT_W'(1)))
    else $error("restart did not reset the walk");

  // A carve adds exactly one visited cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> visited_q == $past(visited_q) + CNT_W'(1))
    else $error("carve did not count the new cell");

  // Backtrack never pops the start cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> sp_q > CNT_W'(1))
    else $error("pop with only the start cell on the stack");

endmodule
